/* hdl/ura_pkg.sv */
// Package for the register-access slave: frame characters, frame lengths,
// register map and the response record. Used by framer, tx and top level.
package ura_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h0A;
  localparam logic [7:0] CH_WRITE = 8'h57;
  localparam logic [7:0] CH_READ  = 8'h52;

  localparam logic [7:0] LEN_WRITE = 8'd7;
  localparam logic [7:0] LEN_READ  = 8'd6;
  localparam logic [7:0] CAP_LIMIT = 8'd6;
  localparam logic [7:0] POS_ADDR  = 8'd3;

  localparam logic [2:0] RESP_LAST = 3'd6;

  localparam logic [2:0] ADDR_OWN_ID = 3'd0;
  localparam logic [7:0] OWN_ID_RESET = 8'd1;

  localparam int DEFAULT_REG_COUNT   = 16;
  localparam int DEFAULT_FRAME_DEPTH = 16;

  typedef enum logic [2:0] {
    RB_START = 3'd0,
    RB_ID    = 3'd1,
    RB_CMD   = 3'd2,
    RB_ADDR  = 3'd3,
    RB_DATA  = 3'd4,
    RB_SUM   = 3'd5,
    RB_END   = 3'd6
  } ura_resp_pos_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] cmd;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] sum;
  } ura_resp_t;

endpackage

/* hdl/ura_if.sv */
// Stream interfaces for received bytes and response bytes.
// No dependencies.
interface ura_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ura_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

/* hdl/ura_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ura_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ura_framer.sv */
// Input register, frame assembly, frame checks and register file access.
// Depends on ura_pkg, ura_if and ura_ram.
module ura_framer #(
  parameter int REG_COUNT          = ura_pkg::DEFAULT_REG_COUNT,
  parameter int FRAME_BUFFER_DEPTH = ura_pkg::DEFAULT_FRAME_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  ura_rx_if.sink            rx,
  input  logic [7:0]        own_id,
  output logic              resp_valid,
  output ura_pkg::ura_resp_t resp,
  input  logic              resp_take
);
  import ura_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_go;
  logic             frame_open;
  logic [7:0]       byte_count;
  logic [7:0]       cap [1:5];
  logic [2**AW-1:0] reg_valid;
  logic             rd_ok;
  logic [7:0]       rd_data;

  logic             is_start;
  logic             room;
  logic             frame_end;
  logic [7:0]       frame_len;
  logic [7:0]       sum_read;
  logic [7:0]       sum_write;
  logic             frame_ok;
  logic             is_write;
  logic             addr_in_range;
  logic             byte_in_range;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       resp_data;
  ura_resp_t        resp_next;

  assign s1_go    = s1_valid && (!resp_valid || resp_take);
  assign rx.ready = !s1_valid || s1_go;

  assign is_start  = (s1_byte == CH_START);
  assign room      = byte_count < 8'(FRAME_BUFFER_DEPTH);
  assign frame_end = !is_start && frame_open && room && (s1_byte == CH_END);
  assign frame_len = byte_count + 8'd1;

  assign sum_read  = cap[1] + cap[2] + cap[3];
  assign sum_write = sum_read + cap[4];
  assign is_write  = (cap[2] == CH_WRITE);

  always_comb begin
    frame_ok = 1'b0;
    if (cap[1] == own_id) begin
      if (is_write) begin
        frame_ok = (frame_len == LEN_WRITE) && (cap[5] == sum_write);
      end else if (cap[2] == CH_READ) begin
        frame_ok = (frame_len == LEN_READ) && (cap[4] == sum_read);
      end
    end
  end

  assign addr_in_range = ({1'b0, cap[3]} < 9'(REG_COUNT));
  assign byte_in_range = ({1'b0, s1_byte} < 9'(REG_COUNT));

  assign ram_we = s1_go && frame_end && frame_ok && is_write && addr_in_range;
  assign ram_re = s1_go && !is_start && frame_open && (byte_count == POS_ADDR);

  ura_ram #(
    .WIDTH(8),
    .DEPTH(REG_COUNT)
  ) u_regs (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cap[3][AW-1:0]),
    .wdata(cap[4]),
    .re   (ram_re),
    .raddr(s1_byte[AW-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    if (is_write) begin
      resp_data = cap[4];
    end else if (rd_ok) begin
      resp_data = rd_data;
    end else begin
      resp_data = 8'd0;
    end
    resp_next.id   = cap[1];
    resp_next.cmd  = cap[2];
    resp_next.addr = cap[3];
    resp_next.data = resp_data;
    resp_next.sum  = cap[1] + cap[2] + cap[3] + resp_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      frame_open <= 1'b0;
      byte_count <= 8'd0;
      reg_valid  <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (rx.ready) begin
        s1_valid <= rx.valid;
      end
      resp_valid <= (resp_valid && !resp_take) || (s1_go && frame_end && frame_ok);
      if (ram_we) begin
        reg_valid[cap[3][AW-1:0]] <= 1'b1;
      end
      if (s1_go) begin
        if (is_start) begin
          frame_open <= 1'b1;
          byte_count <= 8'd1;
        end else if (frame_open) begin
          if (room && !frame_end) begin
            byte_count <= frame_len;
          end else begin
            frame_open <= 1'b0;
            byte_count <= 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
    if (ram_re) begin
      rd_ok <= byte_in_range && reg_valid[s1_byte[AW-1:0]];
    end
    if (s1_go && frame_end && frame_ok) begin
      resp <= resp_next;
    end
    for (int i = 1; i <= 5; i++) begin
      if (s1_go && !is_start && frame_open && room && (byte_count == 8'(i))) begin
        cap[i] <= s1_byte;
      end
    end
  end

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> byte_count == 8'd0)
    else $error("byte count is nonzero outside a frame");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> (byte_count != 8'd0) && (byte_count <= 8'(FRAME_BUFFER_DEPTH)))
    else $error("byte count out of range inside a frame");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_take |=> resp_valid && $stable(resp))
    else $error("pending response changed before it was taken");

endmodule

/* hdl/ura_tx.sv */
// Response serializer: turns one response record into seven output bytes.
// Depends on ura_pkg and ura_if.
module ura_tx (
  input  logic               clk,
  input  logic               rst,
  input  logic               resp_valid,
  input  ura_pkg::ura_resp_t resp,
  output logic               resp_take,
  ura_tx_if.source           tx
);
  import ura_pkg::*;

  logic          busy;
  ura_resp_pos_t pos;
  ura_resp_t     cur;
  logic          last;
  logic          sent;

  assign last         = (pos == RB_END);
  assign sent         = tx.valid && tx.ready;
  assign resp_take    = resp_valid && (!busy || (sent && last));
  assign tx.valid     = busy;
  assign tx.last_byte = last;

  always_comb begin
    case (pos)
      RB_START: tx.tx_byte = CH_START;
      RB_ID:    tx.tx_byte = cur.id;
      RB_CMD:   tx.tx_byte = cur.cmd;
      RB_ADDR:  tx.tx_byte = cur.addr;
      RB_DATA:  tx.tx_byte = cur.data;
      RB_SUM:   tx.tx_byte = cur.sum;
      RB_END:   tx.tx_byte = CH_END;
      default:  tx.tx_byte = CH_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= RB_START;
    end else begin
      if (resp_take) begin
        busy <= 1'b1;
        pos  <= RB_START;
      end else if (sent) begin
        if (last) begin
          busy <= 1'b0;
          pos  <= RB_START;
        end else begin
          pos <= ura_resp_pos_t'(pos + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (resp_take) begin
      cur <= resp;
    end
  end

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    resp_take |=> busy && pos == RB_START)
    else $error("taken response does not start at its first byte");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !busy |-> pos == RB_START)
    else $error("byte position moved while idle");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    sent && last && !resp_valid |=> !busy)
    else $error("serializer stays busy after the closing byte");

endmodule

/* hdl/uart_register_access_slave.sv */
// Top level of the register-access slave: configuration port, frame
// assembly and response output. Depends on ura_pkg, ura_if, ura_framer, ura_tx.
//
// Received bytes enter on rx (valid/ready); a request is accepted when both
// are high. Frames are '$' id 'W' addr data sum '\n' or '$' id 'R' addr sum
// '\n'; a '$' always restarts a frame. Each good frame produces seven
// response bytes on tx, last_byte set on the closing newline. Bad frames,
// overlong frames and stray bytes produce nothing.
// An accepted byte is registered, then checked and executed; a closing
// newline passes the input register, response register and serializer
// before the first response byte appears. One byte is accepted per cycle
// unless rx is held off. A response holds the tx side for its seven bytes;
// a second finished response waits in a one-entry slot, and only while
// that slot is full is rx held off. When the receiver stalls, tx holds
// its byte and input backs up behind the pending response. The RAM
// register file is read early, on the address byte; frame ends never wait.
// Reset clears the frame state, empties the pipeline, marks every register
// as zero and sets own_id to 1. own_id lives at APB byte address 0.
module uart_register_access_slave #(
  parameter int REG_COUNT          = ura_pkg::DEFAULT_REG_COUNT,
  parameter int FRAME_BUFFER_DEPTH = ura_pkg::DEFAULT_FRAME_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  ura_rx_if.sink      rx,
  ura_tx_if.source    tx,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ura_pkg::*;

  logic      [7:0] own_id;
  logic            resp_valid;
  logic            resp_take;
  ura_resp_t       resp;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_OWN_ID) ? {24'd0, own_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= OWN_ID_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_OWN_ID)) begin
      own_id <= pwdata[7:0];
    end
  end

  ura_framer #(
    .REG_COUNT         (REG_COUNT),
    .FRAME_BUFFER_DEPTH(FRAME_BUFFER_DEPTH)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .own_id    (own_id),
    .resp_valid(resp_valid),
    .resp      (resp),
    .resp_take (resp_take)
  );

  ura_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .resp_valid(resp_valid),
    .resp      (resp),
    .resp_take (resp_take),
    .tx        (tx)
  );

endmodule
